[rtl/fwrk_pkg.sv]
// Package for the fixed-weight word rank/unrank unit.
// Shared widths, codes, sequencer states and the binomial table address helper.
// No dependencies.
`timescale 1ns / 1ps

package fwrk_pkg;

  localparam int SITE_W     = 6;               // site count and bit position width
  localparam int WORD_W     = 63;              // operand and answer width
  localparam int SIZE_W     = 64;              // basis size and binomial value width
  localparam int ADDR_W     = 2 * SITE_W;      // binomial table address {p, k}
  localparam int RAM_DEPTH  = 1 << ADDR_W;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 6;

  // request kinds
  localparam logic KIND_RANK   = 1'b0;
  localparam logic KIND_UNRANK = 1'b1;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_NUM_SITES      = 2'd0,
    CFG_SECTOR_ENABLE  = 2'd1,
    CFG_PARTICLE_COUNT = 2'd2
  } cfg_reg_e;

  // shared adder operation
  typedef enum logic {
    ALU_ADD = 1'b0,
    ALU_SUB = 1'b1
  } alu_op_e;

  // sequencer states, one-hot
  typedef enum logic [6:0] {
    ST_FILL   = 7'b0000001,
    ST_FLUSH  = 7'b0000010,
    ST_IDLE   = 7'b0000100,
    ST_SIZE   = 7'b0001000,
    ST_RANK   = 7'b0010000,
    ST_UNRANK = 7'b0100000,
    ST_DONE   = 7'b1000000
  } state_t;

  // binomial table entry C(p, k) lives at {p, k}
  function automatic logic [ADDR_W-1:0] bin_addr(input logic [SITE_W-1:0] p,
                                                 input logic [SITE_W-1:0] k);
    bin_addr = {p, k};
  endfunction

endpackage

[rtl/fwrk_ifs.sv]
// Valid/ready channel interfaces for the rank/unrank unit.
// Request channel (kind, operand) and response channel (ok, answer, basis_size).
// Depends on fwrk_pkg.
`timescale 1ns / 1ps

interface fwrk_req_if import fwrk_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              kind;
  logic [WORD_W-1:0] operand;

  modport source (output valid, kind, operand, input ready);
  modport sink   (input valid, kind, operand, output ready);
endinterface

interface fwrk_rsp_if import fwrk_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              ok;
  logic [WORD_W-1:0] answer;
  logic [SIZE_W-1:0] basis_size;

  modport source (output valid, ok, answer, basis_size, input ready);
  modport sink   (input valid, ok, answer, basis_size, output ready);
endinterface

[rtl/fwrk_alu.sv]
// Shared 64-bit add/subtract unit of the rank/unrank unit.
// Subtract carry out is high when a >= b.
// Depends on fwrk_pkg.
`timescale 1ns / 1ps

module fwrk_alu import fwrk_pkg::*; (
  input  alu_op_e           op,
  input  logic [SIZE_W-1:0] a,
  input  logic [SIZE_W-1:0] b,
  output logic [SIZE_W-1:0] res,
  output logic              carry
);

  logic [SIZE_W-1:0] b_eff;
  logic              cin;

  // two's complement subtract through the same adder
  always_comb begin
    b_eff = (op == ALU_SUB) ? ~b : b;
    cin   = (op == ALU_SUB);
  end

  assign {carry, res} = {1'b0, a} + {1'b0, b_eff} + {{SIZE_W{1'b0}}, cin};

endmodule

[rtl/fwrk_binom_ram.sv]
// Binomial coefficient memory: one write port, two registered read ports.
// Filled by the sequencer after reset; contents undefined until then.
// Depends on fwrk_pkg.
`timescale 1ns / 1ps

module fwrk_binom_ram import fwrk_pkg::*; (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [SIZE_W-1:0] wdata,
  input  logic [ADDR_W-1:0] raddr_a,
  input  logic [ADDR_W-1:0] raddr_b,
  output logic [SIZE_W-1:0] rdata_a,
  output logic [SIZE_W-1:0] rdata_b
);

  logic [SIZE_W-1:0] mem [RAM_DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered reads
  always_ff @(posedge clk) begin
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

[rtl/fixed_weight_word_rank_unrank_unit.sv]
// Top level of the fixed-weight word rank/unrank unit.
// Sequencer, config registers, binomial memory and the shared adder.
// Depends on fwrk_pkg, fwrk_ifs, fwrk_alu, fwrk_binom_ram.
//
//   channel  | dir | handshake     | payload
//   ---------+-----+---------------+-----------------------------------------
//   req      | in  | valid / ready | kind (1), operand (63)
//   rsp      | out | valid / ready | ok (1), answer (63), basis_size (64)
//   cfg      | in  | cfg_we        | cfg_index (2), cfg_data (6)
//
// Reset (rst, synchronous) starts a table build that writes C(p,k) for p,k in
// 0..63 into the binomial memory; req.ready stays low meanwhile.
// A sector rank or unrank walks one bit position per cycle through the single
// adder and the registered memory reads; requests that need no walk go from
// the basis size step straight to the result.
// One word is in work at a time; a finished result may wait in the output
// register while the next word is accepted.
`timescale 1ns / 1ps

module fixed_weight_word_rank_unrank_unit import fwrk_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  fwrk_req_if.sink              req,
  fwrk_rsp_if.source            rsp,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  // configuration
  logic [SITE_W-1:0] num_sites;
  logic              sector_enable;
  logic [SITE_W-1:0] particle_count;

  // sequencer and work registers
  state_t            state;
  logic              kind_r;
  logic [WORD_W-1:0] operand_r;
  logic [SITE_W-1:0] p;
  logic [SITE_W-1:0] k;
  logic [SITE_W-1:0] k_issue;
  logic [SIZE_W-1:0] work;
  logic [WORD_W-1:0] word_r;
  logic              pend;
  logic              bit_d;
  logic [SIZE_W-1:0] size_r;
  logic              res_ok;
  logic [WORD_W-1:0] res_ans;

  // table build
  logic [ADDR_W-1:0] fill_addr;
  logic              wr_pend;
  logic [ADDR_W-1:0] wr_addr_d;
  logic [SIZE_W-1:0] held;
  logic [SIZE_W-1:0] wr_data;
  logic              wr_p0;
  logic              wr_k0;

  // output register
  logic              out_valid;
  logic              out_ok;
  logic [WORD_W-1:0] out_ans;
  logic [SIZE_W-1:0] out_size;

  // datapath
  logic [ADDR_W-1:0] raddr_a;
  logic [ADDR_W-1:0] raddr_b;
  logic [SIZE_W-1:0] rd_a;
  logic [SIZE_W-1:0] rd_b;
  alu_op_e           alu_op;
  logic [SIZE_W-1:0] alu_a;
  logic [SIZE_W-1:0] alu_b;
  logic [SIZE_W-1:0] alu_res;
  logic              alu_carry;

  logic [WORD_W-1:0] hi_mask;
  logic              fits;
  logic              want_le_n;
  logic [SIZE_W-1:0] size_calc;
  logic [SIZE_W-1:0] c_sel;
  logic              take;
  logic [WORD_W-1:0] word_next;

  // handshake outputs
  assign req.ready      = (state == ST_IDLE);
  assign rsp.valid      = out_valid;
  assign rsp.ok         = out_ok;
  assign rsp.answer     = out_ans;
  assign rsp.basis_size = out_size;

  // bits at or above N must be clear for a word to be present
  always_comb begin
    for (int i = 0; i < WORD_W; i++) begin
      hi_mask[i] = (SITE_W'(i) >= num_sites);
    end
  end

  assign fits      = ((operand_r & hi_mask) == '0);
  assign want_le_n = (particle_count <= num_sites);

  // basis size; the sector case reads C(N, n) issued while idle
  always_comb begin
    if (num_sites == '0) begin
      size_calc = '0;
    end else if (!sector_enable) begin
      size_calc = SIZE_W'(1) << num_sites;
    end else if (want_le_n) begin
      size_calc = rd_a;
    end else begin
      size_calc = '0;
    end
  end

  // unrank: k dropped by one since issue selects the second read port
  assign c_sel = (k == k_issue) ? rd_a : rd_b;
  assign take  = (k != '0) && alu_carry;

  always_comb begin
    word_next = word_r;
    if (take) begin
      word_next[p] = 1'b1;
    end
  end

  // table build write data: row 0 is a unit at k = 0, others Pascal sums
  assign wr_p0 = (wr_addr_d[ADDR_W-1:SITE_W] == '0);
  assign wr_k0 = (wr_addr_d[SITE_W-1:0] == '0);
  assign wr_data = wr_p0 ? SIZE_W'(wr_k0) : alu_res;

  // memory read addresses
  always_comb begin
    raddr_a = '0;
    raddr_b = '0;
    unique case (state)
      ST_FILL: begin
        raddr_a = bin_addr(fill_addr[ADDR_W-1:SITE_W] - SITE_W'(1),
                           fill_addr[SITE_W-1:0]);
      end
      ST_IDLE: begin
        raddr_a = bin_addr(num_sites, particle_count);
      end
      ST_SIZE: begin
        raddr_a = bin_addr(num_sites - SITE_W'(1), particle_count);
        raddr_b = bin_addr(num_sites - SITE_W'(1), particle_count - SITE_W'(1));
      end
      ST_RANK: begin
        raddr_a = bin_addr(p, k + SITE_W'(1));
      end
      ST_UNRANK: begin
        raddr_a = bin_addr(p - SITE_W'(1), k);
        raddr_b = bin_addr(p - SITE_W'(1), k - SITE_W'(1));
      end
      ST_FLUSH, ST_DONE: begin
        raddr_a = '0;
      end
      default: begin
        raddr_a = '0;
      end
    endcase
  end

  // shared adder operand selection
  always_comb begin
    alu_op = ALU_ADD;
    alu_a  = '0;
    alu_b  = '0;
    unique case (state)
      ST_FILL, ST_FLUSH: begin
        alu_a = rd_a;
        alu_b = wr_k0 ? '0 : held;
      end
      ST_SIZE: begin
        alu_op = ALU_SUB;
        alu_a  = {1'b0, operand_r};
        alu_b  = size_calc;
      end
      ST_RANK: begin
        alu_a = work;
        alu_b = bit_d ? rd_a : '0;
      end
      ST_UNRANK: begin
        alu_op = ALU_SUB;
        alu_a  = work;
        alu_b  = c_sel;
      end
      ST_IDLE, ST_DONE: begin
        alu_a = '0;
      end
      default: begin
        alu_a = '0;
      end
    endcase
  end

  fwrk_alu u_alu (
    .op    (alu_op),
    .a     (alu_a),
    .b     (alu_b),
    .res   (alu_res),
    .carry (alu_carry)
  );

  fwrk_binom_ram u_ram (
    .clk     (clk),
    .we      (wr_pend),
    .waddr   (wr_addr_d),
    .wdata   (wr_data),
    .raddr_a (raddr_a),
    .raddr_b (raddr_b),
    .rdata_a (rd_a),
    .rdata_b (rd_b)
  );

  // table build pipeline, one entry per cycle
  always_ff @(posedge clk) begin
    wr_addr_d <= fill_addr;
    if (wr_pend) begin
      held <= rd_a;
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_FILL;
      fill_addr      <= '0;
      wr_pend        <= 1'b0;
      out_valid      <= 1'b0;
      pend           <= 1'b0;
      num_sites      <= SITE_W'(1);
      sector_enable  <= 1'b0;
      particle_count <= '0;
    end else begin
      // configuration writes
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_NUM_SITES:      num_sites      <= cfg_data[SITE_W-1:0];
          CFG_SECTOR_ENABLE:  sector_enable  <= cfg_data[0];
          CFG_PARTICLE_COUNT: particle_count <= cfg_data[SITE_W-1:0];
          default: begin
          end
        endcase
      end

      wr_pend <= (state == ST_FILL);

      if (out_valid && rsp.ready) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        ST_FILL: begin
          fill_addr <= fill_addr + ADDR_W'(1);
          if (fill_addr == '1) begin
            state <= ST_FLUSH;
          end
        end

        ST_FLUSH: begin
          state <= ST_IDLE;
        end

        ST_IDLE: begin
          if (req.valid) begin
            kind_r    <= req.kind;
            operand_r <= req.operand;
            state     <= ST_SIZE;
          end
        end

        // basis size and request dispatch
        ST_SIZE: begin
          size_r  <= size_calc;
          res_ok  <= 1'b0;
          res_ans <= '0;
          if (num_sites == '0) begin
            state <= ST_DONE;
          end else if (!sector_enable) begin
            res_ok  <= fits;
            res_ans <= fits ? operand_r : '0;
            state   <= ST_DONE;
          end else begin
            unique case (kind_r)
              KIND_RANK: begin
                if (fits && want_le_n) begin
                  p     <= '0;
                  k     <= '0;
                  work  <= '0;
                  pend  <= 1'b0;
                  state <= ST_RANK;
                end else begin
                  state <= ST_DONE;
                end
              end
              KIND_UNRANK: begin
                if (alu_carry) begin
                  // index not below basis size
                  state <= ST_DONE;
                end else begin
                  p       <= num_sites - SITE_W'(1);
                  k       <= particle_count;
                  k_issue <= particle_count;
                  work    <= {1'b0, operand_r};
                  word_r  <= '0;
                  state   <= ST_UNRANK;
                end
              end
              default: begin
                state <= ST_DONE;
              end
            endcase
          end
        end

        // rank: issue C(p, k+1) per bit, add it in the next cycle if the bit is set
        ST_RANK: begin
          if (pend) begin
            work <= alu_res;
          end
          if (p != num_sites) begin
            pend  <= 1'b1;
            bit_d <= operand_r[p];
            k     <= k + SITE_W'(operand_r[p]);
            p     <= p + SITE_W'(1);
          end else begin
            pend    <= 1'b0;
            res_ok  <= (k == particle_count);
            res_ans <= (k == particle_count) ? alu_res[WORD_W-1:0] : '0;
            state   <= ST_DONE;
          end
        end

        // unrank: greedy walk from the top bit down
        ST_UNRANK: begin
          k_issue <= k;
          word_r  <= word_next;
          if (take) begin
            work <= alu_res;
            k    <= k - SITE_W'(1);
          end
          if (p == '0) begin
            res_ok  <= 1'b1;
            res_ans <= word_next;
            state   <= ST_DONE;
          end else begin
            p <= p - SITE_W'(1);
          end
        end

        // hand the result to the output register
        ST_DONE: begin
          if (!out_valid || rsp.ready) begin
            out_valid <= 1'b1;
            out_ok    <= res_ok;
            out_ans   <= res_ans;
            out_size  <= size_r;
            state     <= ST_IDLE;
          end
        end

        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

[rtl/fwrk_checker.sv]
// Port-level checker for the rank/unrank unit, bound to the top level.
// Watches the request and response handshakes and result consistency.
// Depends on fwrk_pkg and fixed_weight_word_rank_unrank_unit.
`timescale 1ns / 1ps

module fwrk_checker import fwrk_pkg::*; (
  input logic              clk,
  input logic              rst,
  input logic              in_valid,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input logic              out_ok,
  input logic [WORD_W-1:0] out_answer,
  input logic [SIZE_W-1:0] out_basis_size
);

  // one word in work at a time: ready drops after an accept
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("request accepted while a word is in work");

  // a stalled result holds its word
  a_result_holds: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_ok)
      && $stable(out_answer) && $stable(out_basis_size))
    else $error("stalled result changed");

  // a failed lookup answers zero
  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ok |-> out_answer == '0)
    else $error("answer nonzero with ok low");

  // basis size never exceeds 2^63
  a_size_bound: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(out_basis_size[SIZE_W-1] && out_basis_size[SIZE_W-2:0] != '0))
    else $error("basis size above 2^63");

endmodule

bind fixed_weight_word_rank_unrank_unit fwrk_checker u_fwrk_checker (
  .clk            (clk),
  .rst            (rst),
  .in_valid       (req.valid),
  .in_ready       (req.ready),
  .out_valid      (rsp.valid),
  .out_ready      (rsp.ready),
  .out_ok         (rsp.ok),
  .out_answer     (rsp.answer),
  .out_basis_size (rsp.basis_size)
);
